>>> hw/rtl/cost_weighted_lru_cache_unit_macros.svh
// assertion macros used by the cache unit rtl
`ifndef COST_WEIGHTED_LRU_CACHE_UNIT_MACROS_SVH
`define COST_WEIGHTED_LRU_CACHE_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CWL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CWL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/cwlru_pkg.sv
// ----------------------------------------------------------------------------
// cwlru_pkg
// types and constants shared by the cost weighted lru cache
// ----------------------------------------------------------------------------
package cwlru_pkg;

    localparam int KEY_W    = 64;
    localparam int DATA_W   = 32;
    localparam int LEN_W    = 29;
    localparam int BYTE_W   = 32;
    localparam int CNT_W    = 10;
    localparam int STAT_W   = 3;
    localparam int CMD_W    = 2;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [STAT_W-1:0] STATUS_HIT         = 3'd0;
    localparam logic [STAT_W-1:0] STATUS_MISS        = 3'd1;
    localparam logic [STAT_W-1:0] STATUS_INSERTED    = 3'd2;
    localparam logic [STAT_W-1:0] STATUS_KEY_ZERO    = 3'd3;
    localparam logic [STAT_W-1:0] STATUS_OVER_BUDGET = 3'd4;
    localparam logic [STAT_W-1:0] STATUS_CLEARED     = 3'd5;

    localparam logic CFG_BUDGET = 1'b0;
    localparam logic CFG_LIMIT  = 1'b1;

    localparam logic [BYTE_W-1:0] MIN_COST     = 32'd16384;
    localparam logic [BYTE_W-1:0] BUDGET_RESET = 32'd25165824;
    localparam logic [CNT_W-1:0]  LIMIT_RESET  = 10'd512;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_HIT_RD,
        ST_HIT_UNLINK,
        ST_HIT_LINK,
        ST_EV_CHECK,
        ST_EV_APPLY,
        ST_STORE,
        ST_DONE
    } state_t;

endpackage

>>> hw/rtl/cwlru_ram.sv
// ----------------------------------------------------------------------------
// cwlru_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module cwlru_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/cost_weighted_lru_cache_unit.sv
// a lookup scans the tag ram one slot per cycle; a hit then reads the payload and, unless the
// entry is already newest, moves it to newest; a miss ends after the last slot, key zero skips the scan
// insert: scan, then evictions from the oldest end while over budget or limit, then store or over budget
// clear sweeps the tag ram; one transaction at a time; a held result stalls
// reset: budget 25165824, limit 512, then a clearing pass over the tag ram
// with in_ready low; configuration writes are taken throughout
`include "cost_weighted_lru_cache_unit_macros.svh"
// ----------------------------------------------------------------------------
// cost_weighted_lru_cache_unit
// keyed cache in lru order with a byte budget and entry limit, entries held in rams
// ----------------------------------------------------------------------------
module cost_weighted_lru_cache_unit #(
    parameter int ENTRIES = 512
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic                            cfg_index,
    input  logic [cwlru_pkg::BYTE_W-1:0]    cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [cwlru_pkg::CMD_W-1:0]     command,
    input  logic [cwlru_pkg::KEY_W-1:0]     key,
    input  logic [cwlru_pkg::DATA_W-1:0]    data_handle,
    input  logic [cwlru_pkg::LEN_W-1:0]     source_length,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [cwlru_pkg::STAT_W-1:0]    status,
    output logic [cwlru_pkg::DATA_W-1:0]    data_out,
    output logic [cwlru_pkg::CNT_W-1:0]     evicted_count,
    output logic [cwlru_pkg::CNT_W-1:0]     entry_count,
    output logic [cwlru_pkg::BYTE_W-1:0]    used_bytes
);
    import cwlru_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int LW = (CW > CNT_W) ? CW : CNT_W;
    localparam logic [IW-1:0] LAST_SLOT = IW'(ENTRIES - 1);
    localparam int TAG_W = KEY_W + 1;

    state_t              state_reg, state_next;
    logic [BYTE_W-1:0]   budget_reg;
    logic [CNT_W-1:0]    limit_reg;
    logic [IW-1:0]       oldest_reg, oldest_next;
    logic [IW-1:0]       newest_reg, newest_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [BYTE_W-1:0]   bytes_reg, bytes_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [DATA_W-1:0]   handle_reg, handle_next;
    logic [BYTE_W-1:0]   cost_reg, cost_next;
    logic [IW-1:0]       scan_addr_reg, scan_addr_next;
    logic                issued_all_reg, issued_all_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [IW-1:0]       rd_idx_reg, rd_idx_next;
    logic [IW-1:0]       hit_slot_reg, hit_slot_next;
    logic [IW-1:0]       free_slot_reg, free_slot_next;
    logic                free_found_reg, free_found_next;
    logic                clr_cmd_reg, clr_cmd_next;
    logic [STAT_W-1:0]   res_status_reg, res_status_next;
    logic [DATA_W-1:0]   res_data_reg, res_data_next;
    logic [CW-1:0]       evict_cnt_reg, evict_cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic [DATA_W-1:0]   data_out_reg, data_out_next;
    logic [CNT_W-1:0]    evicted_reg, evicted_next;
    logic [CNT_W-1:0]    entry_cnt_reg, entry_cnt_next;
    logic [BYTE_W-1:0]   used_reg, used_next;

    // ram ports
    logic              tag_we, pay_we, cost_we, newer_we, older_we;
    logic [IW-1:0]     tag_waddr, pay_waddr, cost_waddr, newer_waddr, older_waddr;
    logic [TAG_W-1:0]  tag_wdata, tag_rdata;
    logic [DATA_W-1:0] pay_wdata, pay_rdata;
    logic [BYTE_W-1:0] cost_wdata, cost_rdata;
    logic [IW-1:0]     newer_wdata, newer_rdata, newer_raddr;
    logic [IW-1:0]     older_wdata, older_rdata;

    logic [BYTE_W-1:0] len_cost;
    logic [LW-1:0]     count_ext, limit_ext, limit_eff;
    logic              over_bytes, over_count;

    cwlru_ram #(.WIDTH(TAG_W), .DEPTH(ENTRIES)) u_tag_ram (
        .clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
        .raddr(scan_addr_reg), .rdata(tag_rdata)
    );

    cwlru_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_pay_ram (
        .clk(clk), .we(pay_we), .waddr(pay_waddr), .wdata(pay_wdata),
        .raddr(hit_slot_reg), .rdata(pay_rdata)
    );

    cwlru_ram #(.WIDTH(BYTE_W), .DEPTH(ENTRIES)) u_cost_ram (
        .clk(clk), .we(cost_we), .waddr(cost_waddr), .wdata(cost_wdata),
        .raddr(oldest_reg), .rdata(cost_rdata)
    );

    cwlru_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_newer_ram (
        .clk(clk), .we(newer_we), .waddr(newer_waddr), .wdata(newer_wdata),
        .raddr(newer_raddr), .rdata(newer_rdata)
    );

    cwlru_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_older_ram (
        .clk(clk), .we(older_we), .waddr(older_waddr), .wdata(older_wdata),
        .raddr(hit_slot_reg), .rdata(older_rdata)
    );

    assign len_cost   = {source_length, 3'b000};
    assign count_ext  = LW'(count_reg);
    assign limit_ext  = LW'(limit_reg);
    assign limit_eff  = (limit_ext < LW'(ENTRIES)) ? limit_ext : LW'(ENTRIES);
    assign over_bytes = ({1'b0, bytes_reg} + {1'b0, cost_reg}) > {1'b0, budget_reg};
    assign over_count = count_ext >= limit_eff;
    assign newer_raddr = (state_reg == ST_HIT_RD) ? hit_slot_reg : oldest_reg;

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign data_out      = data_out_reg;
    assign evicted_count = evicted_reg;
    assign entry_count   = entry_cnt_reg;
    assign used_bytes    = used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= BUDGET_RESET;
            limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_BUDGET: budget_reg <= cfg_data;
                CFG_LIMIT:  limit_reg  <= cfg_data[CNT_W-1:0];
                default:    budget_reg <= budget_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            oldest_reg     <= '0;
            newest_reg     <= '0;
            count_reg      <= '0;
            bytes_reg      <= '0;
            scan_addr_reg  <= '0;
            issued_all_reg <= 1'b0;
            rd_pend_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            clr_cmd_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            oldest_reg     <= oldest_next;
            newest_reg     <= newest_next;
            count_reg      <= count_next;
            bytes_reg      <= bytes_next;
            scan_addr_reg  <= scan_addr_next;
            issued_all_reg <= issued_all_next;
            rd_pend_reg    <= rd_pend_next;
            free_found_reg <= free_found_next;
            clr_cmd_reg    <= clr_cmd_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        handle_reg     <= handle_next;
        cost_reg       <= cost_next;
        rd_idx_reg     <= rd_idx_next;
        hit_slot_reg   <= hit_slot_next;
        free_slot_reg  <= free_slot_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        evict_cnt_reg  <= evict_cnt_next;
        status_reg     <= status_next;
        data_out_reg   <= data_out_next;
        evicted_reg    <= evicted_next;
        entry_cnt_reg  <= entry_cnt_next;
        used_reg       <= used_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        oldest_next     = oldest_reg;
        newest_next     = newest_reg;
        count_next      = count_reg;
        bytes_next      = bytes_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        handle_next     = handle_reg;
        cost_next       = cost_reg;
        scan_addr_next  = scan_addr_reg;
        issued_all_next = issued_all_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        hit_slot_next   = hit_slot_reg;
        free_slot_next  = free_slot_reg;
        free_found_next = free_found_reg;
        clr_cmd_next    = clr_cmd_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        evict_cnt_next  = evict_cnt_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        data_out_next   = data_out_reg;
        evicted_next    = evicted_reg;
        entry_cnt_next  = entry_cnt_reg;
        used_next       = used_reg;

        tag_we      = 1'b0;
        tag_waddr   = scan_addr_reg;
        tag_wdata   = '0;
        pay_we      = 1'b0;
        pay_waddr   = free_slot_reg;
        pay_wdata   = handle_reg;
        cost_we     = 1'b0;
        cost_waddr  = free_slot_reg;
        cost_wdata  = cost_reg;
        newer_we    = 1'b0;
        newer_waddr = newest_reg;
        newer_wdata = free_slot_reg;
        older_we    = 1'b0;
        older_waddr = free_slot_reg;
        older_wdata = newest_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                // sweep clears every valid flag in the tag ram
                tag_we = 1'b1;
                scan_addr_next = scan_addr_reg + 1'b1;
                if (scan_addr_reg == LAST_SLOT)
                begin
                    scan_addr_next = '0;
                    state_next = clr_cmd_reg ? ST_DONE : ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next        = command;
                    key_next        = key;
                    handle_next     = data_handle;
                    cost_next       = (len_cost < MIN_COST) ? MIN_COST : len_cost;
                    res_data_next   = data_handle;
                    evict_cnt_next  = '0;
                    scan_addr_next  = '0;
                    issued_all_next = 1'b0;
                    free_found_next = 1'b0;
                    clr_cmd_next    = 1'b0;
                    if (command == CMD_CLEAR)
                    begin
                        clr_cmd_next    = 1'b1;
                        oldest_next     = '0;
                        newest_next     = '0;
                        count_next      = '0;
                        bytes_next      = '0;
                        res_status_next = STATUS_CLEARED;
                        state_next      = ST_CLEAR;
                    end
                    else if (key == '0)
                    begin
                        res_status_next = (command == CMD_INSERT) ? STATUS_KEY_ZERO
                                                                  : STATUS_MISS;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (!issued_all_reg)
                begin
                    rd_pend_next = 1'b1;
                    rd_idx_next  = scan_addr_reg;
                    if (scan_addr_reg == LAST_SLOT)
                    begin
                        issued_all_next = 1'b1;
                    end
                    else
                    begin
                        scan_addr_next = scan_addr_reg + 1'b1;
                    end
                end
                if (rd_pend_reg)
                begin
                    if (tag_rdata[KEY_W] && tag_rdata[KEY_W-1:0] == key_reg)
                    begin
                        hit_slot_next = rd_idx_reg;
                        rd_pend_next  = 1'b0;
                        state_next    = ST_HIT_RD;
                    end
                    else
                    begin
                        if (!tag_rdata[KEY_W] && !free_found_reg)
                        begin
                            free_slot_next  = rd_idx_reg;
                            free_found_next = 1'b1;
                        end
                        if (rd_idx_reg == LAST_SLOT)
                        begin
                            rd_pend_next = 1'b0;
                            if (cmd_reg == CMD_INSERT)
                            begin
                                state_next = ST_EV_CHECK;
                            end
                            else
                            begin
                                res_status_next = STATUS_MISS;
                                state_next      = ST_DONE;
                            end
                        end
                    end
                end
            end

            ST_HIT_RD:
            begin
                state_next = ST_HIT_UNLINK;
            end

            ST_HIT_UNLINK:
            begin
                res_status_next = STATUS_HIT;
                res_data_next   = pay_rdata;
                if (hit_slot_reg == newest_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    // take the hit slot out of the chain
                    if (hit_slot_reg == oldest_reg)
                    begin
                        oldest_next = newer_rdata;
                    end
                    else
                    begin
                        newer_we    = 1'b1;
                        newer_waddr = older_rdata;
                        newer_wdata = newer_rdata;
                    end
                    older_we    = 1'b1;
                    older_waddr = newer_rdata;
                    older_wdata = older_rdata;
                    state_next  = ST_HIT_LINK;
                end
            end

            ST_HIT_LINK:
            begin
                newer_we    = 1'b1;
                newer_waddr = newest_reg;
                newer_wdata = hit_slot_reg;
                older_we    = 1'b1;
                older_waddr = hit_slot_reg;
                older_wdata = newest_reg;
                newest_next = hit_slot_reg;
                state_next  = ST_DONE;
            end

            ST_EV_CHECK:
            begin
                // cost and newer link of the oldest slot are read here
                if (count_reg != '0 && (over_bytes || over_count))
                begin
                    state_next = ST_EV_APPLY;
                end
                else if (cost_reg > budget_reg || !free_found_reg)
                begin
                    res_status_next = STATUS_OVER_BUDGET;
                    state_next      = ST_DONE;
                end
                else
                begin
                    state_next = ST_STORE;
                end
            end

            ST_EV_APPLY:
            begin
                tag_we         = 1'b1;
                tag_waddr      = oldest_reg;
                bytes_next     = bytes_reg - cost_rdata;
                evict_cnt_next = evict_cnt_reg + 1'b1;
                // lowest free slot may now be one just evicted
                if (!free_found_reg || oldest_reg < free_slot_reg)
                begin
                    free_slot_next  = oldest_reg;
                    free_found_next = 1'b1;
                end
                if (count_reg <= CW'(1))
                begin
                    oldest_next = '0;
                    newest_next = '0;
                    count_next  = '0;
                end
                else
                begin
                    oldest_next = newer_rdata;
                    count_next  = count_reg - 1'b1;
                end
                state_next = ST_EV_CHECK;
            end

            ST_STORE:
            begin
                tag_we     = 1'b1;
                tag_waddr  = free_slot_reg;
                tag_wdata  = {1'b1, key_reg};
                pay_we     = 1'b1;
                cost_we    = 1'b1;
                bytes_next = bytes_reg + cost_reg;
                count_next = count_reg + 1'b1;
                newest_next = free_slot_reg;
                if (count_reg == '0)
                begin
                    oldest_next = free_slot_reg;
                end
                else
                begin
                    newer_we = 1'b1;
                    older_we = 1'b1;
                end
                res_status_next = STATUS_INSERTED;
                state_next      = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    data_out_next  = res_data_reg;
                    evicted_next   = CNT_W'(LW'(evict_cnt_reg));
                    entry_cnt_next = CNT_W'(count_ext);
                    used_next      = bytes_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `CWL_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_ext <= LW'(ENTRIES),
        "entry count above capacity")
    `CWL_ASSERT_NOW(a_empty_no_bytes, clk, rst_n, count_reg == '0, bytes_reg == '0,
        "bytes held with no entries")
    `CWL_ASSERT_NOW(a_clear_empty, clk, rst_n, out_valid_reg && status_reg == STATUS_CLEARED,
        entry_cnt_reg == '0 && used_reg == '0, "clear result not empty")
    `CWL_ASSERT_NOW(a_evict_only_insert, clk, rst_n,
        out_valid_reg && status_reg != STATUS_INSERTED && status_reg != STATUS_OVER_BUDGET,
        evicted_reg == '0, "eviction reported outside insert")
    `CWL_ASSERT_NEXT(a_hit_moves_newest, clk, rst_n, state_reg == ST_HIT_LINK,
        newest_reg == $past(hit_slot_reg), "hit slot not made newest")

endmodule
